// ===== design/jrdn_pkg.sv =====
// Shared types and constants for the radial deadzone joystick normalizer.
package jrdn_pkg;

	localparam int COORD_W = 16;
	localparam int DZ_W    = 15;
	localparam int QBITS   = 15;   // quotient bits, 0..16384
	localparam int SQ_W    = 32;   // one squared coordinate or the sum of two
	localparam int REM_W   = 59;   // a^2 << 28
	localparam int PRD_W   = 47;   // q * s
	localparam int CFG_IDX_W = 2;

	localparam logic [DZ_W-1:0] LEFT_DZ_RST  = 15'd7849;
	localparam logic [DZ_W-1:0] RIGHT_DZ_RST = 15'd8689;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_DZ  = 2'd0,
		REG_RIGHT_DZ = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] left_x;
		logic signed [COORD_W-1:0] left_y;
		logic signed [COORD_W-1:0] right_x;
		logic signed [COORD_W-1:0] right_y;
	} in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] left_dir_x;
		logic signed [COORD_W-1:0] left_dir_y;
		logic signed [COORD_W-1:0] right_dir_x;
		logic signed [COORD_W-1:0] right_dir_y;
	} out_t;

endpackage

// ===== design/jrdn_stick.sv =====
// One stick datapath: squares, deadzone test, bit-per-stage unit direction.
module jrdn_stick (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [jrdn_pkg::COORD_W-1:0] x,
	input  logic signed [jrdn_pkg::COORD_W-1:0] y,
	input  logic        [jrdn_pkg::DZ_W-1:0]    dz,
	output logic signed [jrdn_pkg::COORD_W-1:0] dir_x,
	output logic signed [jrdn_pkg::COORD_W-1:0] dir_y
);
	localparam int NQ = jrdn_pkg::QBITS;

	logic [jrdn_pkg::COORD_W-1:0] ax, ay;
	logic [jrdn_pkg::SQ_W-1:0]    sqx_s1, sqy_s1;
	logic [2*jrdn_pkg::DZ_W-1:0]  dzsq_s1;
	logic                         negx_s1, negy_s1;

	assign ax = x[jrdn_pkg::COORD_W-1] ? (~x + 16'd1) : x;
	assign ay = y[jrdn_pkg::COORD_W-1] ? (~y + 16'd1) : y;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1  <= ax * ax;
			sqy_s1  <= ay * ay;
			dzsq_s1 <= dz * dz;
			negx_s1 <= x[jrdn_pkg::COORD_W-1];
			negy_s1 <= y[jrdn_pkg::COORD_W-1];
		end
	end

	// iteration chain; entry 0 is stage 2, entry j+1 follows quotient bit NQ-1-j
	logic [jrdn_pkg::SQ_W-1:0]  s_sk    [0:NQ];
	logic                       zero_sk [0:NQ];
	logic                       negx_sk [0:NQ];
	logic                       negy_sk [0:NQ];
	logic [jrdn_pkg::REM_W-1:0] remx_sk [0:NQ];
	logic [jrdn_pkg::REM_W-1:0] remy_sk [0:NQ];
	logic [jrdn_pkg::PRD_W-1:0] px_sk   [0:NQ];
	logic [jrdn_pkg::PRD_W-1:0] py_sk   [0:NQ];
	logic [NQ-1:0]              qx_sk   [0:NQ];
	logic [NQ-1:0]              qy_sk   [0:NQ];

	logic [jrdn_pkg::SQ_W-1:0] s_sum;
	assign s_sum = sqx_s1 + sqy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			s_sk[0]    <= s_sum;
			zero_sk[0] <= s_sum <= {2'b00, dzsq_s1};
			negx_sk[0] <= negx_s1;
			negy_sk[0] <= negy_s1;
			remx_sk[0] <= {sqx_s1[jrdn_pkg::REM_W-29:0], 28'd0};
			remy_sk[0] <= {sqy_s1[jrdn_pkg::REM_W-29:0], 28'd0};
			px_sk[0]   <= '0;
			py_sk[0]   <= '0;
			qx_sk[0]   <= '0;
			qy_sk[0]   <= '0;
		end
	end

	for (genvar j = 0; j < NQ; j++) begin : g_bit
		localparam int K = NQ - 1 - j;
		logic [63:0] dx, dy, sk;
		logic        tx, ty;

		// cost of setting bit K: (2*q*s << K) + (s << 2K)
		assign sk = {32'd0, s_sk[j]} << K;
		assign dx = ({17'd0, px_sk[j]} << (K + 1)) + ({32'd0, s_sk[j]} << (2 * K));
		assign dy = ({17'd0, py_sk[j]} << (K + 1)) + ({32'd0, s_sk[j]} << (2 * K));
		assign tx = dx <= {5'd0, remx_sk[j]};
		assign ty = dy <= {5'd0, remy_sk[j]};

		always_ff @(posedge clk) begin
			if (en) begin
				s_sk[j+1]    <= s_sk[j];
				zero_sk[j+1] <= zero_sk[j];
				negx_sk[j+1] <= negx_sk[j];
				negy_sk[j+1] <= negy_sk[j];
				remx_sk[j+1] <= tx ? remx_sk[j] - dx[jrdn_pkg::REM_W-1:0] : remx_sk[j];
				remy_sk[j+1] <= ty ? remy_sk[j] - dy[jrdn_pkg::REM_W-1:0] : remy_sk[j];
				px_sk[j+1]   <= tx ? px_sk[j] + sk[jrdn_pkg::PRD_W-1:0] : px_sk[j];
				py_sk[j+1]   <= ty ? py_sk[j] + sk[jrdn_pkg::PRD_W-1:0] : py_sk[j];
				qx_sk[j+1]   <= qx_sk[j] | (NQ'(tx) << K);
				qy_sk[j+1]   <= qy_sk[j] | (NQ'(ty) << K);
			end
		end
	end

	logic [jrdn_pkg::COORD_W-1:0] qx_w, qy_w;
	assign qx_w = {1'b0, qx_sk[NQ]};
	assign qy_w = {1'b0, qy_sk[NQ]};

	always_comb begin
		if (zero_sk[NQ]) begin
			dir_x = '0;
			dir_y = '0;
		end else begin
			dir_x = negx_sk[NQ] ? (~qx_w + 16'd1) : qx_w;
			dir_y = negy_sk[NQ] ? (~qy_w + 16'd1) : qy_w;
		end
	end

endmodule

// ===== design/joystick_radial_deadzone_normalizer_unit.sv =====
// Top level of the radial deadzone joystick normalizer.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------
//  in      | in  | in_valid / in_stall    | in_data  (jrdn_pkg::in_t)
//  out     | out | out_valid / out_stall  | out_data (jrdn_pkg::out_t)
//  cfg     | in  | cfg_we                 | cfg_idx, cfg_data
//
// One transfer per cycle while in_stall is low. The path holds 18 register
// stages: squares, loaded at the transfer edge, sum and deadzone test,
// 15 restoring quotient-bit stages, output register.
// Reset clears valid bits and loads the deadzone registers; data regs are not reset.
// The whole pipeline advances when the output register is empty or taken;
// otherwise every stage holds and in_stall is raised.
module joystick_radial_deadzone_normalizer_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  jrdn_pkg::in_t                        in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output jrdn_pkg::out_t                       out_data,
	input  logic                                 cfg_we,
	input  logic [jrdn_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [jrdn_pkg::DZ_W-1:0]            cfg_data
);
	// stages inside each stick unit: square, sum, one per quotient bit
	localparam int NSTG = jrdn_pkg::QBITS + 2;

	logic [jrdn_pkg::DZ_W-1:0] left_dz_q, right_dz_q;
	logic [NSTG-1:0]           vld_q;
	logic                      advance;
	jrdn_pkg::out_t            res;

	// config writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_dz_q  <= jrdn_pkg::LEFT_DZ_RST;
			right_dz_q <= jrdn_pkg::RIGHT_DZ_RST;
		end else if (cfg_we) begin
			case (jrdn_pkg::reg_idx_t'(cfg_idx))
				jrdn_pkg::REG_LEFT_DZ:  left_dz_q  <= cfg_data;
				jrdn_pkg::REG_RIGHT_DZ: right_dz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = !out_valid || !out_stall;
	assign in_stall = !advance;

	jrdn_stick u_left (
		.clk   (clk),
		.en    (advance),
		.x     (in_data.left_x),
		.y     (in_data.left_y),
		.dz    (left_dz_q),
		.dir_x (res.left_dir_x),
		.dir_y (res.left_dir_y)
	);

	jrdn_stick u_right (
		.clk   (clk),
		.en    (advance),
		.x     (in_data.right_x),
		.y     (in_data.right_y),
		.dz    (right_dz_q),
		.dir_x (res.right_dir_x),
		.dir_y (res.right_dir_y)
	);

	// valid bits follow the data through the stick pipelines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else if (advance) begin
			vld_q     <= {vld_q[NSTG-2:0], in_valid};
			out_valid <= vld_q[NSTG-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data <= res;
		end
	end

	a_stall_rule: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("in_stall does not follow output occupancy");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && vld_q[NSTG-1]) |=> out_valid)
		else $error("finished item lost before output register");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> (vld_q == $past(vld_q)))
		else $error("pipeline moved while held");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.left_dir_x <= 16'sd16384)
			&& (out_data.left_dir_x >= -16'sd16384)
			&& (out_data.right_dir_y <= 16'sd16384)
			&& (out_data.right_dir_y >= -16'sd16384)))
		else $error("direction outside unit range");

endmodule
